FILE: rtl/bba_pkg.sv
// Shared node state codes, result status codes and configuration constants of the buddy allocator.
package bba_pkg;

  // Width of the pool size register and its value after reset.
  localparam int CFG_W      = 5;
  localparam int POOL_RESET = 10;
  localparam int STATUS_W   = 2;

  // State of one node of the block tree.
  typedef enum logic [1:0] {
    NODE_INSIDE = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_ALLOC  = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_state_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

FILE: rtl/buddy_block_allocator.sv
// Binary buddy allocator: block tree held in one single-port node memory, walked by a sequencer.
//
// One transaction in, one result out. Every node of the block tree is one word of a single-port
// memory with registered read data: its state and a mask of the block sizes that are free
// somewhere below it, so an allocation finds the smallest free block, lowest offset first, by
// reading one node per level. The memory port does one access per cycle and sets the rate.
// An allocation walks down to the chosen block, splits the levels below it and updates the
// masks back up to the root; a free walks down to the block and back up, merging buddies on
// the way. Errors found at the input go straight to the result. A result that waits for
// out_ready holds the sequencer. A pool size write is taken only while the block is idle or
// sweeping. After reset and after every write of pool_log2 the node memory is swept, one
// entry a cycle, while no transaction is taken.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MIN_LOG2 = 5,
  parameter int MAX_LOG2 = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_W-1:0]                pool_log2,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [MAX_LOG2:0]               request_bytes,
  input  logic [MAX_LOG2-1:0]             block_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [MAX_LOG2-1:0]             granted_offset,
  output logic [$clog2(MAX_LOG2+2)-1:0]   granted_log2,
  output logic [STATUS_W-1:0]             status
);

  localparam int TD = MAX_LOG2 - MIN_LOG2;
  localparam int MW = TD + 1;
  localparam int AW = TD + 1;
  localparam int DW = $clog2(TD + 1);
  localparam int IW = TD;
  localparam int OW = MAX_LOG2;
  localparam int LW = $clog2(MAX_LOG2 + 2);
  localparam int NW = 2 + MW;

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_ROOT_RD  = 14'b00000000000100,
    S_ROOT_WT  = 14'b00000000001000,
    S_ADESC_RD = 14'b00000000010000,
    S_ADESC_WT = 14'b00000000100000,
    S_SPLIT_L  = 14'b00000001000000,
    S_SPLIT_R  = 14'b00000010000000,
    S_FDESC_RD = 14'b00000100000000,
    S_FDESC_WT = 14'b00001000000000,
    S_UP_RD    = 14'b00010000000000,
    S_UP_WT    = 14'b00100000000000,
    S_UP_SIB   = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } seq_state_t;

  // Address of node idx at the given depth of the tree.
  function automatic logic [AW-1:0] node_addr(input logic [DW-1:0] d, input logic [IW-1:0] i);
    node_addr = ((AW'(1) << d) - AW'(1)) + AW'(i);
  endfunction

  // Mask with only the bit of one relative level set.
  function automatic logic [MW-1:0] lvl_bit(input logic [DW-1:0] r);
    lvl_bit = MW'(1) << r;
  endfunction

  // Mask with the bits of relative levels a up to b-1 set.
  function automatic logic [MW-1:0] lvl_range(input logic [DW-1:0] a, input logic [DW-1:0] b);
    lvl_range = ((MW'(1) << b) - MW'(1)) & ~((MW'(1) << a) - MW'(1));
  endfunction

  // Pool size clamped into the supported range, relative to the smallest block.
  function automatic logic [DW-1:0] pool_clamp(input logic [CFG_W-1:0] v);
    if (int'(v) < MIN_LOG2) begin
      pool_clamp = '0;
    end else if (int'(v) > MAX_LOG2) begin
      pool_clamp = DW'(TD);
    end else begin
      pool_clamp = DW'(int'(v) - MIN_LOG2);
    end
  endfunction

  // Request rounded up to a power of two, never below the smallest block.
  function automatic logic [LW-1:0] req_log2(input logic [MAX_LOG2:0] req);
    logic [LW-1:0] k;
    k = LW'(MIN_LOG2);
    for (int j = MIN_LOG2; j <= MAX_LOG2; j++) begin
      if (req > ((MAX_LOG2+1)'(1) << j)) begin
        k = LW'(j + 1);
      end
    end
    req_log2 = k;
  endfunction

  seq_state_t          state;
  logic [AW-1:0]       clr_cnt;
  logic [DW-1:0]       pool_rel;
  logic [OW-1:0]       off_q;
  logic [DW-1:0]       rk;
  logic [DW-1:0]       r_l;
  logic [DW-1:0]       tgt_d;
  logic [DW-1:0]       cur_d;
  logic [IW-1:0]       cur_i;
  logic [DW-1:0]       cur_r;
  node_state_t         cur_state;
  logic [MW-1:0]       cur_mask;
  logic                merging;
  logic [DW-1:0]       sp_d;
  logic [IW-1:0]       sp_i;
  logic [DW-1:0]       sp_r;
  logic [OW-1:0]       res_off;
  logic [LW-1:0]       res_lg;
  logic [STATUS_W-1:0] res_st;

  logic [NW-1:0]       mem [0:(2**AW)-1];
  logic [NW-1:0]       rd_q;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_addr;
  logic [NW-1:0]       mem_wdata;

  node_state_t         rd_state;
  logic [MW-1:0]       rd_mask;
  logic [LW-1:0]       pool_abs;
  logic [LW-1:0]       req_k;
  logic                fit_found;
  logic [DW-1:0]       fit_r;
  logic                merge_go;
  logic [DW-1:0]       adesc_d;
  logic [IW-1:0]       adesc_i;
  logic [DW-1:0]       f_lvl_rel;
  logic [LW-1:0]       f_lvl_abs;
  logic [OW-1:0]       f_low_mask;
  logic                f_bit;

  assign rd_state  = node_state_t'(rd_q[NW-1 -: 2]);
  assign rd_mask   = rd_q[MW-1:0];
  assign pool_abs  = LW'(pool_rel) + LW'(MIN_LOG2);
  assign req_k     = req_log2(request_bytes);
  assign merge_go  = merging && (rd_state == NODE_FREE);
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // Next node on the way down to the chosen free block.
  assign adesc_d = cur_d + DW'(1);
  assign adesc_i = IW'({cur_i, ~rd_mask[r_l]});

  // Level of the node on the way down to a block being freed.
  assign f_lvl_rel  = pool_rel - cur_d;
  assign f_lvl_abs  = LW'(f_lvl_rel) + LW'(MIN_LOG2);
  assign f_low_mask = ~({OW{1'b1}} << f_lvl_abs);
  assign f_bit      = 1'(off_q >> (f_lvl_abs - LW'(1)));

  // Smallest level at or above the request that has a free block somewhere in the pool.
  always_comb begin
    fit_found = 1'b0;
    fit_r     = '0;
    for (int j = 0; j < MW; j++) begin
      if (!fit_found && (j >= int'(rk)) && (j <= int'(pool_rel)) && rd_mask[j]) begin
        fit_found = 1'b1;
        fit_r     = DW'(j);
      end
    end
  end

  // Node memory port: one read or one write a cycle, chosen by the sequencer.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        if (clr_cnt == '0) begin
          mem_wdata = {NODE_FREE, lvl_bit(pool_rel)};
        end
      end
      S_ROOT_RD: begin
        mem_re = 1'b1;
      end
      S_ADESC_RD: begin
        mem_re   = 1'b1;
        mem_addr = node_addr(adesc_d, IW'({cur_i, 1'b0}));
      end
      S_SPLIT_L: begin
        if (sp_r != rk) begin
          mem_we   = 1'b1;
          mem_addr = node_addr(sp_d + DW'(1), IW'({sp_i, 1'b0}));
          if ((sp_r - DW'(1)) == rk) begin
            mem_wdata = {NODE_ALLOC, {MW{1'b0}}};
          end else begin
            mem_wdata = {NODE_SPLIT, lvl_range(rk, sp_r - DW'(1))};
          end
        end
      end
      S_SPLIT_R: begin
        mem_we    = 1'b1;
        mem_addr  = node_addr(sp_d + DW'(1), IW'({sp_i, 1'b1}));
        mem_wdata = {NODE_FREE, lvl_bit(sp_r - DW'(1))};
      end
      S_FDESC_RD: begin
        mem_re   = 1'b1;
        mem_addr = node_addr(cur_d, cur_i);
      end
      S_UP_RD: begin
        if (cur_d == '0) begin
          mem_we    = 1'b1;
          mem_wdata = {cur_state, cur_mask};
        end else begin
          mem_re   = 1'b1;
          mem_addr = node_addr(cur_d, cur_i ^ IW'(1));
        end
      end
      S_UP_WT: begin
        mem_we   = 1'b1;
        mem_addr = node_addr(cur_d, cur_i);
        if (!merge_go) begin
          mem_wdata = {cur_state, cur_mask};
        end
      end
      S_UP_SIB: begin
        mem_we   = 1'b1;
        mem_addr = node_addr(cur_d, cur_i ^ IW'(1));
      end
      S_IDLE, S_ROOT_WT, S_ADESC_WT, S_FDESC_WT, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Node memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Sequencer: walks the tree down to find or locate a block, then back up to fix the masks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      pool_rel  <= pool_clamp(CFG_W'(POOL_RESET));
      out_valid <= 1'b0;
    end else begin
      // The output register empties when its transaction is taken.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        // A new pool size restarts the sweep of the node memory.
        pool_rel <= pool_clamp(pool_log2);
        clr_cnt  <= '0;
        state    <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_cnt <= clr_cnt + AW'(1);
            if (clr_cnt == {AW{1'b1}}) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              off_q   <= block_offset;
              res_off <= '0;
              res_lg  <= '0;
              cur_d   <= '0;
              cur_i   <= '0;
              if (!action) begin
                if (req_k > pool_abs) begin
                  res_st <= ST_OOM;
                  state  <= S_DONE;
                end else begin
                  rk     <= DW'(req_k - LW'(MIN_LOG2));
                  res_lg <= req_k;
                  res_st <= ST_OK;
                  state  <= S_ROOT_RD;
                end
              end else if ((block_offset >> pool_abs) != '0) begin
                res_st <= ST_INVALID;
                state  <= S_DONE;
              end else begin
                res_st <= ST_OK;
                state  <= S_FDESC_RD;
              end
            end
          end
          S_ROOT_RD: begin
            state <= S_ROOT_WT;
          end
          S_ROOT_WT: begin
            if (!fit_found) begin
              res_st <= ST_OOM;
              res_lg <= '0;
              state  <= S_DONE;
            end else begin
              r_l   <= fit_r;
              tgt_d <= pool_rel - fit_r;
              if (fit_r == pool_rel) begin
                // The whole pool is the chosen block.
                cur_state <= (fit_r == rk) ? NODE_ALLOC : NODE_SPLIT;
                cur_mask  <= (fit_r == rk) ? '0 : lvl_range(rk, fit_r);
                cur_r     <= fit_r;
                merging   <= 1'b0;
                sp_d      <= '0;
                sp_i      <= '0;
                sp_r      <= fit_r;
                res_off   <= '0;
                state     <= S_SPLIT_L;
              end else begin
                state <= S_ADESC_RD;
              end
            end
          end
          S_ADESC_RD: begin
            state <= S_ADESC_WT;
          end
          S_ADESC_WT: begin
            cur_d <= adesc_d;
            cur_i <= adesc_i;
            if (adesc_d == tgt_d) begin
              cur_state <= (r_l == rk) ? NODE_ALLOC : NODE_SPLIT;
              cur_mask  <= (r_l == rk) ? '0 : lvl_range(rk, r_l);
              cur_r     <= r_l;
              merging   <= 1'b0;
              sp_d      <= adesc_d;
              sp_i      <= adesc_i;
              sp_r      <= r_l;
              res_off   <= OW'(adesc_i) << (LW'(r_l) + LW'(MIN_LOG2));
              state     <= S_SPLIT_L;
            end else begin
              state <= S_ADESC_RD;
            end
          end
          S_SPLIT_L: begin
            state <= (sp_r == rk) ? S_UP_RD : S_SPLIT_R;
          end
          S_SPLIT_R: begin
            sp_d  <= sp_d + DW'(1);
            sp_i  <= IW'({sp_i, 1'b0});
            sp_r  <= sp_r - DW'(1);
            state <= S_SPLIT_L;
          end
          S_FDESC_RD: begin
            state <= S_FDESC_WT;
          end
          S_FDESC_WT: begin
            priority if (rd_state == NODE_SPLIT && f_lvl_rel != '0) begin
              cur_d <= cur_d + DW'(1);
              cur_i <= IW'({cur_i, f_bit});
              state <= S_FDESC_RD;
            end else if (rd_state == NODE_ALLOC && (off_q & f_low_mask) == '0) begin
              cur_state <= NODE_FREE;
              cur_mask  <= lvl_bit(f_lvl_rel);
              cur_r     <= f_lvl_rel;
              merging   <= 1'b1;
              res_lg    <= f_lvl_abs;
              state     <= S_UP_RD;
            end else begin
              res_st <= ST_INVALID;
              state  <= S_DONE;
            end
          end
          S_UP_RD: begin
            state <= (cur_d == '0) ? S_DONE : S_UP_WT;
          end
          S_UP_WT: begin
            if (merge_go) begin
              state <= S_UP_SIB;
            end else begin
              cur_state <= NODE_SPLIT;
              cur_mask  <= cur_mask | rd_mask;
              merging   <= 1'b0;
              cur_d     <= cur_d - DW'(1);
              cur_i     <= cur_i >> 1;
              cur_r     <= cur_r + DW'(1);
              state     <= S_UP_RD;
            end
          end
          S_UP_SIB: begin
            // Both buddies are gone; their parent becomes one free block.
            cur_state <= NODE_FREE;
            cur_mask  <= lvl_bit(cur_r + DW'(1));
            cur_d     <= cur_d - DW'(1);
            cur_i     <= cur_i >> 1;
            cur_r     <= cur_r + DW'(1);
            state     <= S_UP_RD;
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid      <= 1'b1;
              granted_offset <= res_off;
              granted_log2   <= res_lg;
              status         <= res_st;
              state          <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // A pool size write blocks new transactions until the sweep is over.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("transaction taken during the node memory sweep");

  // An error result carries neither offset nor size.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_offset == '0 && granted_log2 == '0))
    else $error("error result with non-zero offset or size");

  // A granted block lies inside the pool.
  a_in_pool: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> ((granted_offset >> pool_abs) == '0))
    else $error("granted block outside the pool");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the buddy block allocator, with its own tree predictor.
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int MIN_LG    = 5;
  localparam int MAX_LG    = 16;
  localparam int NODES     = (1 << (MAX_LG - MIN_LG + 1)) - 1;
  localparam int CYCLE_CAP = 1000000;
  localparam int PHASE_LEN = 48;

  // Action codes of the request channel.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic [15:0] offset;
    logic [4:0]  lg;
    logic [1:0]  status;
  } grant_t;

  // Block tree predictor and store of the grants still awaited from the block.
  class alloc_scoreboard;
    node_state_t tree[NODES];
    int unsigned pool_lg;
    grant_t      awaited[$];
    int unsigned live[$];
    int          errors;

    function int unsigned node(int unsigned d, int unsigned i);
      return ((1 << d) - 1) + i;
    endfunction

    // Writing the pool size clamps it and leaves one free block.
    function void init_pool(logic [4:0] raw);
      pool_lg = 32'(raw);
      if (pool_lg < MIN_LG) pool_lg = MIN_LG;
      if (pool_lg > MAX_LG) pool_lg = MAX_LG;
      foreach (tree[n]) tree[n] = NODE_INSIDE;
      tree[0] = NODE_FREE;
      live.delete();
    endfunction

    function grant_t grant_block(logic [16:0] req);
      grant_t g;
      int unsigned k, d, i;
      g = '0;
      g.status = ST_OOM;
      k = MIN_LG;
      while (k < 17 && (64'd1 << k) < 64'(req)) k++;
      if (k > pool_lg) return g;
      for (int unsigned lvl = k; lvl <= pool_lg; lvl++) begin
        d = pool_lg - lvl;
        for (int unsigned j = 0; j < (1 << d); j++) begin
          if (tree[node(d, j)] == NODE_FREE) begin
            i = j;
            // Split down to the wanted size, keeping the lower half.
            while (d < pool_lg - k) begin
              tree[node(d, i)] = NODE_SPLIT;
              d++;
              i = i << 1;
              tree[node(d, i)] = NODE_FREE;
              tree[node(d, i + 1)] = NODE_FREE;
            end
            tree[node(d, i)] = NODE_ALLOC;
            g.offset = 16'(i << k);
            g.lg = 5'(k);
            g.status = ST_OK;
            live = {live, 32'(g.offset)};
            return g;
          end
        end
      end
      return g;
    endfunction

    function grant_t release_block(logic [15:0] off);
      grant_t g;
      int unsigned d, i;
      g = '0;
      g.status = ST_INVALID;
      if (32'(off) >= (32'd1 << pool_lg)) return g;
      for (int unsigned lvl = MIN_LG; lvl <= pool_lg; lvl++) begin
        if ((32'(off) & ((32'd1 << lvl) - 1)) != 0) break;
        d = pool_lg - lvl;
        i = 32'(off) >> lvl;
        if (tree[node(d, i)] == NODE_ALLOC) begin
          tree[node(d, i)] = NODE_FREE;
          // Merge upward while the true buddy is free.
          while (d > 0 && tree[node(d, i ^ 1)] == NODE_FREE) begin
            tree[node(d, i)] = NODE_INSIDE;
            tree[node(d, i ^ 1)] = NODE_INSIDE;
            d--;
            i = i >> 1;
            tree[node(d, i)] = NODE_FREE;
          end
          g.lg = 5'(lvl);
          g.status = ST_OK;
          foreach (live[n]) if (live[n] == 32'(off)) begin
            live.delete(n);
            break;
          end
          return g;
        end
      end
      return g;
    endfunction

    // Called for every accepted request transaction.
    function void note_request(logic act, logic [16:0] req, logic [15:0] off);
      if (act == ACT_ALLOC) awaited = {awaited, grant_block(req)};
      else awaited = {awaited, release_block(off)};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Called for every accepted result transaction.
    task check_grant(logic [15:0] off, logic [4:0] lg, logic [1:0] st);
      grant_t e;
      if (awaited.size() == 0) begin
        report("result with nothing awaited");
        return;
      end
      e = awaited.pop_front();
      if (off !== e.offset) report($sformatf("granted_offset %0h, wanted %0h", off, e.offset));
      if (lg !== e.lg) report($sformatf("granted_log2 %0d, wanted %0d", lg, e.lg));
      if (st !== e.status) report($sformatf("status %0d, wanted %0d", st, e.status));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    pool_log2;
  logic                in_valid;
  logic                in_ready;
  logic                action;
  logic [16:0]         request_bytes;
  logic [15:0]         block_offset;
  logic                out_valid;
  logic                out_ready;
  logic [15:0]         granted_offset;
  logic [4:0]          granted_log2;
  logic [STATUS_W-1:0] status;

  alloc_scoreboard sb;
  int unsigned     cycles = 0;

  buddy_block_allocator u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .pool_log2      (pool_log2),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .request_bytes  (request_bytes),
    .block_offset   (block_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted_offset (granted_offset),
    .granted_log2   (granted_log2),
    .status         (status)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[buddy_block_allocator] ERROR");
      $finish;
    end
  end

  // Result transactions are checked at the edge at which they are taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_grant(granted_offset, granted_log2, status);
  end

  // Receiver stalls: long ready stretches, short stalls and a few long ones.
  initial begin
    int r;
    out_ready <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (r < 90) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Drive one request transaction, wait for it to be taken, then idle for a random gap that may be zero.
  task automatic send(logic act, logic [16:0] req, logic [15:0] off);
    int unsigned gap;
    in_valid      <= 1'b1;
    action        <= act;
    request_bytes <= req;
    block_offset  <= off;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, req, off);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every awaited result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool(logic [4:0] v);
    cfg_valid <= 1'b1;
    pool_log2 <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.init_pool(v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random request: mostly sized allocations and frees of live blocks, some noise.
  task automatic random_request();
    int r;
    int unsigned k, top;
    logic [16:0] req;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      top = (sb.pool_lg > MIN_LG + 2) ? sb.pool_lg - 2 : sb.pool_lg;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(MIN_LG, sb.pool_lg)
                                       : $urandom_range(MIN_LG, top);
      if (k == MIN_LG) req = 17'($urandom_range(0, 1 << MIN_LG));
      else req = 17'($urandom_range((1 << (k - 1)) + 1, 1 << k));
      send(ACT_ALLOC, req, 16'($urandom));
    end else if (r < 85 && sb.live.size() != 0) begin
      send(ACT_FREE, 17'($urandom), 16'(sb.live[$urandom_range(0, sb.live.size() - 1)]));
    end else if (r < 93) begin
      send(ACT_ALLOC, 17'($urandom_range(0, 65536)), 16'($urandom));
    end else begin
      send(ACT_FREE, 17'($urandom), 16'($urandom));
    end
  endtask

  // Main sequence: directed cases, then random phases over a range of pool sizes.
  initial begin
    logic [4:0] pools[9] = '{5'd5, 5'd16, 5'd0, 5'd31, 5'd7, 5'd12, 5'd3, 5'd20, 5'd10};
    sb = new();
    sb.init_pool(5'(POOL_RESET));
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    pool_log2     <= 5'(POOL_RESET);
    in_valid      <= 1'b0;
    action        <= ACT_ALLOC;
    request_bytes <= '0;
    block_offset  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on a 1 KiB pool.
    write_pool(5'd10);
    send(ACT_ALLOC, 17'd0, 16'd0);        // zero request gets the smallest block
    send(ACT_ALLOC, 17'd1, 16'd0);
    send(ACT_ALLOC, 17'd33, 16'd0);       // rounded up to 64
    send(ACT_ALLOC, 17'd65536, 16'hFFFF); // larger than the pool
    send(ACT_ALLOC, 17'd1024, 16'd0);     // no block that large left
    send(ACT_FREE, 17'd0, 16'd16);        // unaligned offset
    send(ACT_FREE, 17'h1FFFF, 16'hFFFF);  // offset outside the pool
    send(ACT_FREE, 17'd0, 16'd32);
    send(ACT_FREE, 17'd0, 16'd32);        // double free
    send(ACT_FREE, 17'd0, 16'd0);         // merges with its buddy
    send(ACT_FREE, 17'd0, 16'd64);        // pool whole again
    send(ACT_ALLOC, 17'd1024, 16'd0);
    send(ACT_ALLOC, 17'd32, 16'd0);       // pool full
    send(ACT_FREE, 17'd0, 16'd0);
    send(ACT_ALLOC, 17'd512, 16'd0);
    send(ACT_ALLOC, 17'd257, 16'd0);
    send(ACT_ALLOC, 17'd31, 16'd0);
    send(ACT_ALLOC, 17'd32, 16'd0);
    send(ACT_ALLOC, 17'd1000, 16'd0);
    send(ACT_FREE, 17'd0, 16'd512);
    send(ACT_FREE, 17'd0, 16'd0);
    drain();

    // Random phases, each with its own pool size; one phase pauses part way.
    foreach (pools[p]) begin
      write_pool(pools[p]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 1 && n == 20) drain();
        random_request();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
